### design/mdc_pkg.sv
// Shared types and constants for the MESI direct-mapped cache controller.
// Holds transaction structs, MESI and bus command codes, and the line store control struct.
// No dependencies.
package mdc_pkg;

   localparam int ADDR_BITS = 32;
   localparam int INDEX_BITS_DEF = 10;
   localparam int OFFSET_BITS_DEF = 6;
   localparam int WB_TAG_BITS = 16;
   localparam int REQ_ID_BITS = 8;

   localparam logic [2:0] ACT_CPU_READ = 3'd0;
   localparam logic [2:0] ACT_CPU_WRITE = 3'd1;
   localparam logic [2:0] ACT_SNOOP_READ = 3'd2;
   localparam logic [2:0] ACT_SNOOP_WRITE = 3'd3;
   localparam logic [2:0] ACT_SNOOP_UPGRADE = 3'd4;

   typedef enum logic [1:0] {
      MESI_I = 2'd0,
      MESI_S = 2'd1,
      MESI_E = 2'd2,
      MESI_M = 2'd3
   } mesi_state_type;

   typedef enum logic [1:0] {
      BUS_NONE = 2'd0,
      BUS_READ = 2'd1,
      BUS_READ_EXCL = 2'd2,
      BUS_UPGRADE = 2'd3
   } bus_cmd_type;

   typedef enum logic [0:0] {
      CLR_SWEEP = 1'b0,
      CLR_READY = 1'b1
   } clr_state_type;

   typedef struct packed {
      logic [2:0] action;
      logic [ADDR_BITS-1:0] address;
      logic others_hold_line;
   } req_type;

   typedef struct packed {
      logic hit;
      bus_cmd_type bus_command;
      logic write_back;
      logic [WB_TAG_BITS-1:0] write_back_tag;
      logic supplies_line;
      mesi_state_type new_state;
      logic protocol_error;
      logic [REQ_ID_BITS-1:0] request_source;
   } rsp_type;

   typedef struct packed {
      logic state_we;
      logic tag_we;
      mesi_state_type state;
   } mdc_wr_ctl_type;

endpackage

### design/mdc_line_ram.sv
// Tag and MESI state memories with registered reads and a post-reset clear sweep.
// Depends on mdc_pkg for the state enum, the sweep FSM type and the write control struct.
module mdc_line_ram
   import mdc_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   parameter int TAG_BITS = ADDR_BITS - INDEX_BITS_DEF - OFFSET_BITS_DEF
) (
   input logic clock,
   input logic reset,
   output logic ready,
   input logic [INDEX_BITS-1:0] rd_index,
   output mesi_state_type rd_state,
   output logic [TAG_BITS-1:0] rd_tag,
   input mdc_wr_ctl_type wr_ctl,
   input logic [INDEX_BITS-1:0] wr_index,
   input logic [TAG_BITS-1:0] wr_tag
);

   localparam int LINES = 2 ** INDEX_BITS;

   mesi_state_type state_mem [LINES];
   logic [TAG_BITS-1:0] tag_mem [LINES];

   mesi_state_type rd_state_ff;
   logic [TAG_BITS-1:0] rd_tag_ff;

   clr_state_type clr_state_ff, clr_state_in;
   logic [INDEX_BITS-1:0] clr_index_ff, clr_index_in;
   logic sweeping;

   logic st_we;
   logic [INDEX_BITS-1:0] st_addr;
   mesi_state_type st_data;

   always_comb begin
      case (clr_state_ff)
         CLR_SWEEP: begin
            if (clr_index_ff == '1) begin
               clr_state_in = CLR_READY;
            end else begin
               clr_state_in = CLR_SWEEP;
            end
         end
         CLR_READY: begin
            clr_state_in = CLR_READY;
         end
         default: begin
            clr_state_in = CLR_SWEEP;
         end
      endcase
   end

   always_comb begin
      case (clr_state_ff)
         CLR_SWEEP: begin
            sweeping = 1'b1;
            ready = 1'b0;
         end
         CLR_READY: begin
            sweeping = 1'b0;
            ready = 1'b1;
         end
         default: begin
            sweeping = 1'b1;
            ready = 1'b0;
         end
      endcase
   end

   assign clr_index_in = sweeping ? clr_index_ff + 1'b1 : clr_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_state_ff <= CLR_SWEEP;
         clr_index_ff <= '0;
      end else begin
         clr_state_ff <= clr_state_in;
         clr_index_ff <= clr_index_in;
      end
   end

   assign st_we = sweeping || wr_ctl.state_we;
   assign st_addr = sweeping ? clr_index_ff : wr_index;
   assign st_data = sweeping ? MESI_I : wr_ctl.state;

   always_ff @(posedge clock) begin
      if (st_we) begin
         state_mem[st_addr] <= st_data;
      end
      rd_state_ff <= state_mem[rd_index];
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.tag_we) begin
         tag_mem[wr_index] <= wr_tag;
      end
      rd_tag_ff <= tag_mem[rd_index];
   end

   assign rd_state = rd_state_ff;
   assign rd_tag = rd_tag_ff;

endmodule

### design/mdc_mesi_logic.sv
// MESI protocol decision for one transaction: hit, bus command, write-back, supply, next state.
// Depends on mdc_pkg for action codes, enums and the result and write control structs.
module mdc_mesi_logic
   import mdc_pkg::*;
(
   input logic item_valid,
   input logic [2:0] action,
   input logic others_hold_line,
   input logic tag_match,
   input mesi_state_type line_state,
   input logic [WB_TAG_BITS-1:0] line_tag,
   input logic [REQ_ID_BITS-1:0] requester_id,
   output rsp_type rsp,
   output mdc_wr_ctl_type wr_ctl
);

   logic hit;

   assign hit = (line_state != MESI_I) && tag_match;

   always_comb begin
      rsp = '0;
      rsp.new_state = line_state;
      wr_ctl.state_we = item_valid;
      wr_ctl.tag_we = 1'b0;
      case (action)
         ACT_CPU_READ, ACT_CPU_WRITE: begin
            rsp.hit = hit;
            if (hit) begin
               if (action == ACT_CPU_WRITE) begin
                  if (line_state == MESI_S) begin
                     rsp.bus_command = BUS_UPGRADE;
                  end
                  rsp.new_state = MESI_M;
               end
            end else begin
               if (line_state == MESI_M) begin
                  rsp.write_back = 1'b1;
                  rsp.write_back_tag = line_tag;
               end
               wr_ctl.tag_we = item_valid;
               if (action == ACT_CPU_READ) begin
                  rsp.bus_command = BUS_READ;
                  rsp.new_state = others_hold_line ? MESI_S : MESI_E;
               end else begin
                  rsp.bus_command = BUS_READ_EXCL;
                  rsp.new_state = MESI_M;
               end
            end
         end
         ACT_SNOOP_READ, ACT_SNOOP_WRITE: begin
            rsp.hit = hit;
            if (hit) begin
               if (line_state == MESI_M) begin
                  rsp.write_back = 1'b1;
                  rsp.write_back_tag = line_tag;
               end
               rsp.supplies_line = 1'b1;
               rsp.new_state = (action == ACT_SNOOP_READ) ? MESI_S : MESI_I;
            end
         end
         ACT_SNOOP_UPGRADE: begin
            rsp.hit = hit;
            if (hit) begin
               if (line_state == MESI_S) begin
                  rsp.new_state = MESI_I;
               end else begin
                  rsp.protocol_error = 1'b1;
               end
            end
         end
         default: begin
            rsp.hit = 1'b0;
         end
      endcase
      rsp.request_source = (rsp.bus_command != BUS_NONE) ? requester_id : '0;
      wr_ctl.state = rsp.new_state;
   end

endmodule

### design/mesi_direct_mapped_cache_ctrl_top.sv
// Top level of the MESI direct-mapped cache tag and state controller.
// Depends on mdc_pkg, mdc_line_ram and mdc_mesi_logic.
//
// Usage:
//   Request channel: drive start with req_data; the transaction is taken at a rising
//   edge where start is high and busy is low. One CPU read or write, or one snooped
//   read, write or upgrade, per transaction.
//   Result channel: rsp_strobe is high for one cycle with rsp_data, once the request
//   has passed the s1 register and the output register. The receiver cannot stall;
//   results are never held back.
//   Config channel: csr_data is written to requester_id when csr_valid is high;
//   csr_ready is always high. Write only while no transaction is in flight.
// Throughput: one transaction per cycle while busy is low. A transaction reads the tag
//   and state memories when accepted and writes the state, and on a CPU miss the tag,
//   in the next cycle; a one-entry bypass forwards it to a read issued in that cycle.
// Reset: synchronous. After reset a clear sweep writes Invalid to every line, one line
//   per cycle, all 2**INDEX_BITS lines (1024 at default); busy is high throughout.
module mesi_direct_mapped_cache_ctrl_top
   import mdc_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input req_type req_data,
   output logic rsp_strobe,
   output rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [REQ_ID_BITS-1:0] csr_data
);

   localparam int TAG_BITS = ADDR_BITS - OFFSET_BITS - INDEX_BITS;

   logic ram_ready;
   logic accept;

   logic [REQ_ID_BITS-1:0] requester_id_ff, requester_id_in;

   logic s1_valid_ff, s1_valid_in;
   req_type s1_req_ff;

   logic byp_valid_ff, byp_valid_in;
   logic [INDEX_BITS-1:0] byp_index_ff;
   mesi_state_type byp_state_ff;
   logic [TAG_BITS-1:0] byp_tag_ff, byp_tag_in;

   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [INDEX_BITS-1:0] rd_index;
   logic [INDEX_BITS-1:0] s1_index;
   logic [TAG_BITS-1:0] s1_tag;
   mesi_state_type mem_state;
   logic [TAG_BITS-1:0] mem_tag;
   logic use_byp;
   mesi_state_type line_state;
   logic [TAG_BITS-1:0] line_tag;
   logic [WB_TAG_BITS-1:0] wb_line_tag;
   logic tag_match;
   mdc_wr_ctl_type wr_ctl;

   assign busy = !ram_ready;
   assign accept = start && ram_ready;
   assign csr_ready = 1'b1;

   assign rd_index = req_data.address[OFFSET_BITS +: INDEX_BITS];
   assign s1_index = s1_req_ff.address[OFFSET_BITS +: INDEX_BITS];
   assign s1_tag = s1_req_ff.address[ADDR_BITS-1 -: TAG_BITS];

   assign use_byp = byp_valid_ff && (byp_index_ff == s1_index);
   assign line_state = use_byp ? byp_state_ff : mem_state;
   assign line_tag = use_byp ? byp_tag_ff : mem_tag;
   assign tag_match = (line_tag == s1_tag);

   generate
      if (TAG_BITS >= WB_TAG_BITS) begin : g_wb_trunc
         assign wb_line_tag = line_tag[WB_TAG_BITS-1:0];
      end else begin : g_wb_ext
         assign wb_line_tag = {{(WB_TAG_BITS - TAG_BITS){1'b0}}, line_tag};
      end
   endgenerate

   mdc_line_ram #(
      .INDEX_BITS(INDEX_BITS),
      .TAG_BITS(TAG_BITS)
   ) u_line_ram (
      .clock(clock),
      .reset(reset),
      .ready(ram_ready),
      .rd_index(rd_index),
      .rd_state(mem_state),
      .rd_tag(mem_tag),
      .wr_ctl(wr_ctl),
      .wr_index(s1_index),
      .wr_tag(s1_tag)
   );

   mdc_mesi_logic u_mesi_logic (
      .item_valid(s1_valid_ff),
      .action(s1_req_ff.action),
      .others_hold_line(s1_req_ff.others_hold_line),
      .tag_match(tag_match),
      .line_state(line_state),
      .line_tag(wb_line_tag),
      .requester_id(requester_id_ff),
      .rsp(rsp_data_in),
      .wr_ctl(wr_ctl)
   );

   assign requester_id_in = (csr_valid && csr_ready) ? csr_data : requester_id_ff;
   assign s1_valid_in = accept;
   assign byp_valid_in = s1_valid_ff;
   assign byp_tag_in = wr_ctl.tag_we ? s1_tag : line_tag;
   assign rsp_strobe_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         requester_id_ff <= '0;
         s1_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         requester_id_ff <= requester_id_in;
         s1_valid_ff <= s1_valid_in;
         byp_valid_ff <= byp_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
      byp_index_ff <= s1_index;
      byp_state_ff <= wr_ctl.state;
      byp_tag_ff <= byp_tag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("accepted transaction produced no result strobe");

   a_empty_in_sweep: assert property (@(posedge clock) disable iff (reset)
      busy |-> !s1_valid_ff && !wr_ctl.state_we)
      else $error("transaction in flight during clear sweep");

   a_error_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.protocol_error |->
         rsp_data.hit && (rsp_data.new_state == MESI_E || rsp_data.new_state == MESI_M))
      else $error("protocol error without hit on exclusive or modified line");

   a_wb_no_upgrade: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.write_back |-> rsp_data.bus_command != BUS_UPGRADE)
      else $error("write-back reported with bus upgrade");
`endif

endmodule
